### hw/rtl/tkm_pkg.sv
// Package for the trie keyword matcher: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package tkm_pkg;
  localparam int MaxStates  = 256;
  localparam int MaxRules   = 512;
  localparam int StateW     = $clog2(MaxStates);
  localparam int RuleW      = $clog2(MaxRules);
  localparam int RuleCntW   = RuleW + 1;
  localparam int StateCntW  = StateW + 1;
  localparam int ValueW     = 32;

  localparam logic [1:0] FuncParse   = 2'd0;
  localparam logic [1:0] FuncInstall = 2'd1;
  localparam logic [1:0] FuncClear   = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  // APB byte address of the miss value register
  localparam logic [1:0] RegReject = 2'd0;

  localparam logic [7:0] EndChar = 8'd0;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_VAL, S_OUT
  } tkm_state_t;

  // one rule memory entry
  typedef struct packed {
    logic [StateW-1:0] owner;
    logic [7:0]        chr;
    logic [StateW-1:0] target;
  } rule_t;

  // search unit control and result
  typedef struct packed {
    logic              start;
    logic [StateW-1:0] owner;
    logic [7:0]        chr;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [StateW-1:0] target;
  } srch_rsp_t;
endpackage
`default_nettype wire

### hw/rtl/trie_keyword_matcher.sv
// Trie keyword matcher top level: sequencer, state value memory, APB register.
// Depends on tkm_pkg and tkm_search.
// Rules are searched by a linear scan, one rule memory read per cycle; a hit stops early.
// A character is accepted only while idle with no result waiting, so the next one waits
// until the last is through; clear, ignored and skipped items leave the sequencer idle.
// Reset: synchronous; empties the table, miss value reads 0.
`default_nettype none
module trie_keyword_matcher import tkm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // func[1:0], ch[9:2], value[41:10], zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // result_value[31:0], status[33:32], zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  tkm_state_t state, state_next;
  logic [ValueW-1:0]    miss_value;
  logic [RuleCntW-1:0]  rule_used;
  logic [StateCntW-1:0] states_used;
  logic [StateW-1:0]    current_state;
  logic                 skipping;
  logic [1:0]           pending_status;
  logic [1:0]           func;
  logic [7:0]           chr;
  logic [ValueW-1:0]    value;
  logic [ValueW-1:0]    state_value [MaxStates];
  logic [ValueW-1:0]    sv_rd;
  logic                 sv_wr;
  logic                 found;
  logic [ValueW-1:0]    res_value;
  logic [1:0]           res_status;
  srch_req_t req;
  srch_rsp_t rsp;
  logic                 r_wr;
  rule_t                r_data;
  logic                 full_rule, full_state;

  assign pready = 1'b1;
  assign prdata = miss_value;
  always_ff @(posedge clk) begin
    if (rst) miss_value <= '0;
    else if (psel && penable && pwrite && paddr == RegReject) miss_value <= pwdata;
  end

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {6'd0, res_status, res_value};
  assign full_rule  = rule_used >= RuleCntW'(MaxRules);
  assign full_state = states_used >= StateCntW'(MaxStates);

  assign req.start = state == S_READ;
  assign req.owner = current_state;
  assign req.chr   = chr;

  tkm_search u_search (
    .clk(clk), .rst(rst), .req(req), .rule_used(rule_used),
    .wr_en(r_wr), .wr_addr(rule_used[RuleW-1:0]), .wr_data(r_data), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (sv_wr) state_value[current_state] <= value;
    sv_rd <= state_value[current_state];
  end

  // only parse and install characters outside a skip need the rule search
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid && s_tready && !skipping &&
                  (s_tdata[1:0] == FuncParse || s_tdata[1:0] == FuncInstall))
                state_next = S_READ;
      S_READ: state_next = S_CMP;
      S_CMP:  if (rsp.done) state_next = S_VAL;
      S_VAL:  state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sv_wr  = 1'b0;
    r_wr   = 1'b0;
    r_data = '0;
    if (state == S_VAL && !found && func == FuncInstall) begin
      r_data.owner  = current_state;
      r_data.chr    = chr;
      r_data.target = (chr == EndChar) ? '0 : states_used[StateW-1:0];
      r_wr = !full_rule && !(chr != EndChar && full_state);
    end
    // end rule writes the value (new or existing)
    if (state == S_VAL && func == FuncInstall && chr == EndChar &&
        (found || !full_rule)) sv_wr = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      rule_used      <= '0;
      states_used    <= StateCntW'(1);
      current_state  <= '0;
      skipping       <= 1'b0;
      pending_status <= StOk;
      found          <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (s_tvalid && s_tready) begin
        func  <= s_tdata[1:0];
        chr   <= s_tdata[9:2];
        value <= s_tdata[41:10];
        if (s_tdata[1:0] == FuncClear) begin
          rule_used      <= '0;
          states_used    <= StateCntW'(1);
          current_state  <= '0;
          skipping       <= 1'b0;
          pending_status <= StOk;
        end else if (skipping && s_tdata[9:2] == EndChar &&
                     (s_tdata[1:0] == FuncParse || s_tdata[1:0] == FuncInstall)) begin
          res_value      <= miss_value;
          res_status     <= pending_status;
          m_tvalid       <= 1'b1;
          current_state  <= '0;
          skipping       <= 1'b0;
          pending_status <= StOk;
        end
      end
      if (state == S_CMP && rsp.done) found <= rsp.found;
      if (state == S_CMP && rsp.done && rsp.found && chr != EndChar)
        current_state <= rsp.target;
      if (state == S_VAL && !found) begin
        if (func == FuncParse) begin
          if (chr == EndChar) begin
            res_value <= miss_value; res_status <= StMiss; m_tvalid <= 1'b1;
            current_state <= '0;
          end else begin
            skipping <= 1'b1; pending_status <= StMiss;
          end
        end else if (chr == EndChar) begin
          m_tvalid <= 1'b1;
          current_state <= '0;
          if (full_rule) begin
            res_value <= miss_value; res_status <= StFull;
          end else begin
            rule_used <= rule_used + 1'b1;
            res_value <= value; res_status <= StOk;
          end
        end else if (full_rule || full_state) begin
          skipping <= 1'b1; pending_status <= StFull;
        end else begin
          rule_used     <= rule_used + 1'b1;
          current_state <= states_used[StateW-1:0];
          states_used   <= states_used + 1'b1;
        end
      end
      // matched end rule: install returns the new value, parse the stored one
      if (state == S_OUT && found && chr == EndChar) begin
        res_value     <= (func == FuncInstall) ? value : sv_rd;
        res_status    <= StOk;
        m_tvalid      <= 1'b1;
        current_state <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/tkm_search.sv
// Rule memory and the sequential rule search (one entry read per cycle).
// Depends on tkm_pkg.
`default_nettype none
module tkm_search import tkm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire srch_req_t           req,
  input  wire logic [RuleCntW-1:0] rule_used,
  input  wire logic                wr_en,
  input  wire logic [RuleW-1:0]    wr_addr,
  input  wire rule_t               wr_data,
  output srch_rsp_t                rsp
);
  rule_t rule_mem [MaxRules];
  rule_t rd_data;
  logic [RuleCntW-1:0] idx;
  logic                busy;
  logic                rd_vld;
  logic [StateW-1:0]   owner;
  logic [7:0]          chr;
  logic                hit;

  always_ff @(posedge clk) begin
    if (wr_en) rule_mem[wr_addr] <= wr_data;
    rd_data <= rule_mem[idx[RuleW-1:0]];
  end

  assign hit = rd_vld && rd_data.owner == owner && rd_data.chr == chr;

  // one address issued per cycle, its entry is compared in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rd_vld <= 1'b0;
      idx    <= '0;
      rsp    <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        rd_vld <= 1'b0;
        idx    <= '0;
        owner  <= req.owner;
        chr    <= req.chr;
      end else if (busy) begin
        if (hit) begin
          busy       <= 1'b0;
          rd_vld     <= 1'b0;
          rsp.done   <= 1'b1;
          rsp.found  <= 1'b1;
          rsp.target <= rd_data.target;
        end else if (idx >= rule_used) begin
          busy      <= 1'b0;
          rd_vld    <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= 1'b0;
        end else begin
          rd_vld <= 1'b1;
          idx    <= idx + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/tkm_checker.sv
// Port-level checks for the trie keyword matcher, bound to the top level.
// Depends on trie_keyword_matcher ports only.
`default_nettype none
module tkm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out hold");
  a_nostat3: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3) else $error("bad status");
  // no input transaction while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid) else $error("accept with result pending");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind trie_keyword_matcher tkm_checker u_tkm_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire
